// ----- src/fdmd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared widths, constants and types for the frame difference motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

    // frame store depth and derived widths
    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int COUNT_W    = ADDR_W + 1;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int DIFF_W = CHAN_W + 2;      // sum of three channel differences

    localparam int SUM_W = 26;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int FP_W  = 17;
    localparam int THR_W = 8;
    localparam int THR3_W  = THR_W + 2;
    localparam int LIMIT_W = COUNT_W + THR3_W;
    localparam int CMP_W   = (LIMIT_W > SUM_W) ? LIMIT_W : SUM_W;

    localparam logic [FP_W-1:0]  FP_RESET  = 17'h10000;
    localparam logic [THR_W-1:0] THR_RESET = 8'd10;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FP_W;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'd1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam int OUT_DATA_W = 32;

    // control that follows a pixel down the pipe
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               use_prev;
        logic [LIMIT_W-1:0] limit;
    } fdmd_ctrl_t;

    typedef struct packed {
        logic             first_frame;
        logic             motion_found;
        logic [SUM_W-1:0] difference_total;
    } fdmd_result_t;

endpackage

// ----- src/frame_difference_motion_detector.sv -----
// ----------------------------------------------------------------------------
// frame_difference_motion_detector
// Per-frame sum of absolute RGB differences against the previous frame.
//
//  channel   dir  fields (low bit first)
//  s_axis    in   tdata: red_level[7:0], green_level[15:8], blue_level[23:16]
//  m_axis    out  tdata: motion_found[0], difference_total[26:1], zero pad
//                 tuser: first_frame
//  cfg       in   index 0 frame_pixels, index 1 threshold_per_channel
//
// One pixel per cycle while s_axis_tready is high; the store reads and writes
// the same entry in the beat's cycle. The frame result passes the store, lane
// and merge registers into a four-entry queue that drives m_axis_tvalid.
// s_axis_tready drops only while that queue plus pixels in flight would be
// full. No clearing pass after reset: the first frame fills the store.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector
    import fdmd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // red, green, blue

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // motion_found, difference_total
    output logic                   m_axis_tuser,   // first_frame

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [FP_W-1:0]  frame_pixels_reg, frame_pixels_next;
    logic [THR_W-1:0] threshold_reg,    threshold_next;

    logic             accept;
    logic [PIX_W-1:0] cur_pixel;
    logic [PIX_W-1:0] old_pixel;
    fdmd_ctrl_t       ctrl;
    logic [CHAN_W-1:0] diff_red, diff_green, diff_blue;
    logic             room;
    fdmd_result_t     res;

    always_comb
    begin
        frame_pixels_next = frame_pixels_reg;
        threshold_next    = threshold_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_PIXELS: frame_pixels_next = cfg_data[FP_W-1:0];
                REG_THRESHOLD:    threshold_next    = cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FP_RESET;
            threshold_reg    <= THR_RESET;
        end
        else
        begin
            frame_pixels_reg <= frame_pixels_next;
            threshold_reg    <= threshold_next;
        end
    end

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fdmd_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (s_axis_tdata),
        .frame_pixels (frame_pixels_reg),
        .threshold    (threshold_reg),
        .cur_pixel    (cur_pixel),
        .old_pixel    (old_pixel),
        .ctrl         (ctrl)
    );

    fdmd_lane u_lane_red (
        .clk       (clk),
        .en        (ctrl.valid),
        .cur_level (cur_pixel[CHAN_W-1:0]),
        .old_level (old_pixel[CHAN_W-1:0]),
        .diff      (diff_red)
    );

    fdmd_lane u_lane_green (
        .clk       (clk),
        .en        (ctrl.valid),
        .cur_level (cur_pixel[2*CHAN_W-1:CHAN_W]),
        .old_level (old_pixel[2*CHAN_W-1:CHAN_W]),
        .diff      (diff_green)
    );

    fdmd_lane u_lane_blue (
        .clk       (clk),
        .en        (ctrl.valid),
        .cur_level (cur_pixel[3*CHAN_W-1:2*CHAN_W]),
        .old_level (old_pixel[3*CHAN_W-1:2*CHAN_W]),
        .diff      (diff_blue)
    );

    fdmd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (ctrl),
        .diff_red   (diff_red),
        .diff_green (diff_green),
        .diff_blue  (diff_blue),
        .room       (room),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = OUT_DATA_W'({res.difference_total, res.motion_found});
    assign m_axis_tuser = res.first_frame;

endmodule

// ----- src/fdmd_store.sv -----
// ----------------------------------------------------------------------------
// fdmd_store
// Previous-frame store with raster position tracking and frame limit.
// ----------------------------------------------------------------------------
module fdmd_store
    import fdmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [PIX_W-1:0]   pixel,
    input  logic [FP_W-1:0]    frame_pixels,
    input  logic [THR_W-1:0]   threshold,
    output logic [PIX_W-1:0]   cur_pixel,
    output logic [PIX_W-1:0]   old_pixel,
    output fdmd_ctrl_t         ctrl
);

    logic [PIX_W-1:0]  mem [MAX_PIXELS];

    logic [ADDR_W-1:0] pos_reg,       pos_next;
    logic              have_prev_reg, have_prev_next;
    fdmd_ctrl_t        ctrl_reg,      ctrl_next;
    logic [PIX_W-1:0]  cur_reg;
    logic [PIX_W-1:0]  rd_reg;

    logic [31:0]        fp_ext;
    logic [31:0]        count_wide;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] pos_ext;
    logic [ADDR_W-1:0]  pos_eff;
    logic               last;
    logic [THR3_W-1:0]  thr3;

    always_comb
    begin
        fp_ext = 32'(frame_pixels);
        if (fp_ext == 32'd0)
        begin
            count_wide = 32'd1;
        end
        else if (fp_ext > 32'(MAX_PIXELS))
        begin
            count_wide = 32'(MAX_PIXELS);
        end
        else
        begin
            count_wide = fp_ext;
        end
        count = count_wide[COUNT_W-1:0];

        // frame shrunk mid-frame: clamp to the new last position
        pos_ext = {1'b0, pos_reg};
        if (pos_ext >= count)
        begin
            pos_eff = ADDR_W'(count - COUNT_W'(1));
        end
        else
        begin
            pos_eff = pos_reg;
        end
        last = (({1'b0, pos_eff} + COUNT_W'(1)) >= count);

        thr3 = {2'b00, threshold} + {1'b0, threshold, 1'b0};

        pos_next       = pos_reg;
        have_prev_next = have_prev_reg;
        ctrl_next.valid    = accept;
        ctrl_next.last     = last;
        ctrl_next.use_prev = have_prev_reg;
        ctrl_next.limit    = LIMIT_W'(count) * LIMIT_W'(thr3);
        if (accept)
        begin
            if (last)
            begin
                pos_next       = '0;
                have_prev_next = 1'b1;
            end
            else
            begin
                pos_next = pos_eff + ADDR_W'(1);
            end
        end
    end

    // read-before-write on the same entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg       <= mem[pos_eff];
            mem[pos_eff] <= pixel;
            cur_reg      <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            have_prev_reg <= 1'b0;
            ctrl_reg      <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            have_prev_reg <= have_prev_next;
            ctrl_reg      <= ctrl_next;
        end
    end

    assign cur_pixel = cur_reg;
    assign old_pixel = rd_reg;
    assign ctrl      = ctrl_reg;

endmodule

// ----- src/fdmd_lane.sv -----
// ----------------------------------------------------------------------------
// fdmd_lane
// One color channel: registered absolute difference against the stored value.
// ----------------------------------------------------------------------------
module fdmd_lane
    import fdmd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [CHAN_W-1:0] cur_level,
    input  logic [CHAN_W-1:0] old_level,
    output logic [CHAN_W-1:0] diff
);

    logic [CHAN_W-1:0] diff_reg, diff_next;

    always_comb
    begin
        if (cur_level > old_level)
        begin
            diff_next = cur_level - old_level;
        end
        else
        begin
            diff_next = old_level - cur_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

// ----- src/fdmd_merge.sv -----
// ----------------------------------------------------------------------------
// fdmd_merge
// Combines lane differences into the frame sum, decides motion, queues results.
// ----------------------------------------------------------------------------
module fdmd_merge
    import fdmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fdmd_ctrl_t        ctrl_in,
    input  logic [CHAN_W-1:0] diff_red,
    input  logic [CHAN_W-1:0] diff_green,
    input  logic [CHAN_W-1:0] diff_blue,
    output logic              room,
    output logic              res_valid,
    input  logic              res_ready,
    output fdmd_result_t      res
);

    fdmd_ctrl_t              ctrl_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    fdmd_result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg,    cnt_next;

    logic [DIFF_W-1:0]  d_total;
    logic [SUM_W:0]     acc;
    logic [SUM_W-1:0]   acc_sat;
    logic               push;
    logic               pop;
    fdmd_result_t       push_data;
    logic [FIFO_CNT_W+1:0] pending;

    always_comb
    begin
        d_total = DIFF_W'(diff_red) + DIFF_W'(diff_green) + DIFF_W'(diff_blue);
        acc     = {1'b0, sum_reg} + (SUM_W + 1)'(d_total);
        acc_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

        push = ctrl_reg.valid && ctrl_reg.last;
        pop  = res_valid && res_ready;

        push_data.first_frame      = !ctrl_reg.use_prev;
        push_data.difference_total = ctrl_reg.use_prev ? acc_sat : '0;
        push_data.motion_found     = ctrl_reg.use_prev &&
            (CMP_W'(acc_sat) > CMP_W'(ctrl_reg.limit));

        sum_next = sum_reg;
        if (ctrl_reg.valid)
        begin
            if (ctrl_reg.last)
            begin
                sum_next = '0;
            end
            else if (ctrl_reg.use_prev)
            begin
                sum_next = acc_sat;
            end
        end

        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

        // every pixel in flight may still produce a result
        pending = (FIFO_CNT_W + 2)'(cnt_reg) + (FIFO_CNT_W + 2)'(ctrl_in.valid)
                + (FIFO_CNT_W + 2)'(ctrl_reg.valid);
        room    = pending < (FIFO_CNT_W + 2)'(FIFO_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            sum_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            ctrl_reg   <= ctrl_in;
            sum_reg    <= sum_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign res_valid = (cnt_reg != '0);
    assign res       = fifo_mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue over depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into full queue");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.last) |=> (sum_reg == '0))
        else $error("frame sum not cleared after last pixel");

    a_first_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && !ctrl_reg.use_prev) |=> (sum_reg == '0))
        else $error("frame sum grew during first frame");
`endif

endmodule
